// ----- sv/serial_line_editor_echo_macros.svh -----
// Assertion macros shared by the serial line editor RTL.
`ifndef SERIAL_LINE_EDITOR_ECHO_MACROS_SVH
`define SERIAL_LINE_EDITOR_ECHO_MACROS_SVH

`ifndef SYNTHESIS

`define SLE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("serial_line_editor_echo: assertion failed");

`define SLE_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("serial_line_editor_echo: forbidden condition seen");

`else

`define SLE_ASSERT(label, clk, rst_n, prop)

`define SLE_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- sv/sle_pkg.sv -----
// Shared types and constants of the serial line editor.
`timescale 1ns / 1ps

package sle_pkg;

	localparam int LINE_STORE_DEPTH = 512;
	localparam int ADDR_W = $clog2(LINE_STORE_DEPTH);

	typedef logic [ADDR_W-1:0] addr_t;

	localparam addr_t LEN_MAX = addr_t'(LINE_STORE_DEPTH - 1);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_CR,
		OP_BS,
		OP_CHAR
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LF1   = 3'd1,
		PH_CHARS = 3'd2,
		PH_CR2   = 3'd3,
		PH_LF2   = 3'd4
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       line_end;
	} result_t;

	typedef struct packed {
		phase_t phase;
		logic   rd_pend;
	} back_status_t;

endpackage

// ----- sv/serial_line_editor_echo.sv -----
// Top level of the serial line editor with echo.
`timescale 1ns / 1ps
`include "serial_line_editor_echo_macros.svh"

// Terminal line editor: each beat pushed is a received byte or a transmitter-ready tick,
// and each popped beat is one byte to send. A two-entry command queue takes one beat per
// cycle, unless it is full, while the back end works; the back end retires one command per
// cycle while the result queue has room, except a tick in the character part of a replay
// while stored characters remain, which holds off the next command until the registered
// read of the 512-byte line store returns. Results wait in a two-entry queue, so a stalled
// consumer holds up the back end only once both entries are taken. The line store needs no
// clearing pass after reset; the block accepts beats from the first cycle out of reset.
module serial_line_editor_echo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] tx_byte,
	output logic       line_end
);

	import sle_pkg::*;

	logic         cmd_valid;
	cmd_t         cmd;
	logic         cmd_take;
	back_status_t status;

	sle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.rx_byte  (rx_byte),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	sle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take),
		.empty    (empty),
		.pop      (pop),
		.tx_byte  (tx_byte),
		.line_end (line_end),
		.status   (status)
	);

	`SLE_ASSERT(a_end_is_lf, clk, arst_n, (!empty && line_end) |-> (tx_byte == CH_LF))
	`SLE_ASSERT(a_rd_in_chars, clk, arst_n, status.rd_pend |-> (status.phase == PH_CHARS))
	`SLE_ASSERT(a_rd_single, clk, arst_n, status.rd_pend |=> !status.rd_pend)
	`SLE_NEVER(a_take_empty, clk, arst_n, cmd_take && !cmd_valid)

endmodule

// ----- sv/sle_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ----- sv/sle_front.sv -----
// Front end: input handshake, event decoding and the command queue.
`timescale 1ns / 1ps

module sle_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          req_type,
	input  logic [7:0]    rx_byte,
	output logic          cmd_valid,
	output sle_pkg::cmd_t cmd,
	input  logic          cmd_take
);

	import sle_pkg::*;

	cmd_t       in_cmd;
	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push_ok;

	always_comb begin
		in_cmd.ch = rx_byte;
		priority if (req_type) begin
			in_cmd.op = OP_TICK;
		end else if (rx_byte == CH_CR) begin
			in_cmd.op = OP_CR;
		end else if (rx_byte == CH_BS) begin
			in_cmd.op = OP_BS;
		end else begin
			in_cmd.op = OP_CHAR;
		end
	end

	assign full      = (count_q == 2'd2);
	assign push_ok   = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push_ok, cmd_take})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/sle_back.sv -----
// Back end: line store, replay sequencer and the result queue.
`timescale 1ns / 1ps

module sle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  sle_pkg::cmd_t         cmd,
	output logic                  cmd_take,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            tx_byte,
	output logic                  line_end,
	output sle_pkg::back_status_t status
);

	import sle_pkg::*;

	phase_t     phase_q, phase_d;
	addr_t      length_q, length_d;
	addr_t      index_q, index_d;
	logic       rd_pend_q;

	result_t    res_q [2];
	logic       ow_q;
	logic       or_q;
	logic [1:0] ocnt_q;

	logic       start, is_tick, idle, more;
	logic       do_cr, do_bs, do_char;
	logic       t_lf1, t_rd, t_cr, t_lf2, t_bad;
	logic       rd_char, rd_end;
	logic       emit, out_pop;
	result_t    emit_res;

	logic       ram_en, ram_we;
	addr_t      ram_addr;
	logic [7:0] ram_rdata;

	sle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_STORE_DEPTH)
	) u_line_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(cmd.ch),
		.rdata(ram_rdata)
	);

	assign start    = cmd_valid && !rd_pend_q && (ocnt_q != 2'd2);
	assign cmd_take = start;
	assign is_tick  = (cmd.op == OP_TICK);
	assign idle     = (phase_q == PH_IDLE);
	assign more     = (index_q < length_q);

	assign do_cr   = start && !is_tick && idle && (cmd.op == OP_CR);
	assign do_bs   = start && !is_tick && idle && (cmd.op == OP_BS) && (length_q != '0);
	assign do_char = start && !is_tick && idle && (cmd.op == OP_CHAR) && (length_q < LEN_MAX);
	assign t_lf1   = start && is_tick && (phase_q == PH_LF1);
	assign t_rd    = start && is_tick && (phase_q == PH_CHARS) && more;
	assign t_cr    = start && is_tick &&
		(((phase_q == PH_CHARS) && !more) || (phase_q == PH_CR2));
	assign t_lf2   = start && is_tick && (phase_q == PH_LF2);
	assign t_bad   = start && is_tick && (phase_q != PH_IDLE) && (phase_q != PH_LF1) &&
		(phase_q != PH_CHARS) && (phase_q != PH_CR2) && (phase_q != PH_LF2);
	assign rd_char = rd_pend_q && (ram_rdata != 8'h00);
	assign rd_end  = rd_pend_q && (ram_rdata == 8'h00);

	// next replay phase
	always_comb begin
		phase_d = phase_q;
		priority if (do_cr) begin
			phase_d = PH_LF1;
		end else if (t_lf1) begin
			phase_d = PH_CHARS;
		end else if (t_cr || rd_end) begin
			phase_d = PH_LF2;
		end else if (t_lf2 || t_bad) begin
			phase_d = PH_IDLE;
		end else begin
			phase_d = phase_q;
		end
	end

	// datapath and result
	always_comb begin
		length_d = length_q;
		index_d  = index_q;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = length_q;
		emit     = 1'b0;
		emit_res = '{tx_byte: cmd.ch, line_end: 1'b0};
		priority if (rd_char) begin
			emit             = 1'b1;
			emit_res.tx_byte = ram_rdata;
			index_d          = index_q + addr_t'(1);
		end else if (rd_end || t_cr || do_cr) begin
			emit             = 1'b1;
			emit_res.tx_byte = CH_CR;
			if (do_cr) begin
				index_d = '0;
			end
		end else if (do_bs) begin
			emit             = 1'b1;
			emit_res.tx_byte = CH_BS;
			length_d         = length_q - addr_t'(1);
		end else if (do_char) begin
			emit     = 1'b1;
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			length_d = length_q + addr_t'(1);
		end else if (t_rd) begin
			ram_en   = 1'b1;
			ram_addr = index_q;
		end else if (t_lf1) begin
			emit             = 1'b1;
			emit_res.tx_byte = CH_LF;
		end else if (t_lf2) begin
			emit              = 1'b1;
			emit_res.tx_byte  = CH_LF;
			emit_res.line_end = 1'b1;
			index_d           = '0;
			length_d          = '0;
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			length_q  <= '0;
			index_q   <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			length_q  <= length_d;
			index_q   <= index_d;
			rd_pend_q <= t_rd;
		end
	end

	assign out_pop  = pop && !empty;
	assign empty    = (ocnt_q == 2'd0);
	assign tx_byte  = res_q[or_q].tx_byte;
	assign line_end = res_q[or_q].line_end;

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q[ow_q] <= emit_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= 1'b0;
			or_q   <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (emit) begin
				ow_q <= !ow_q;
			end
			if (out_pop) begin
				or_q <= !or_q;
			end
			unique case ({emit, out_pop})
				2'b10: ocnt_q <= ocnt_q + 2'd1;
				2'b01: ocnt_q <= ocnt_q - 2'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	assign status = '{phase: phase_q, rd_pend: rd_pend_q};

endmodule

// ----- dv/serial_line_editor_echo_test.sv -----
// Self-checking testbench for the serial line editor: echo, backspace, full line, replay and back-pressure.
`timescale 1ns / 1ps

module serial_line_editor_echo_test;
	import sle_pkg::*;

	localparam bit REQ_RX   = 1'b0;
	localparam bit REQ_TICK = 1'b1;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BEATS = 100;
	localparam int ZERO_AT = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       req_type = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] tx_byte;
	logic       line_end;

	logic [7:0] line_chars [LINE_STORE_DEPTH];
	int         line_len = 0;
	int         replay_pos = 0;
	phase_t     replay_ph = PH_IDLE;
	bit         last_echoed;
	result_t    tx_expected [$];

	int errors = 0;
	bit steady = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	serial_line_editor_echo dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.tx_byte(tx_byte),
		.line_end(line_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic edit_line(input bit req, input logic [7:0] b);
		result_t r;
		r = '0;
		last_echoed = 1'b0;
		if (req == REQ_RX) begin
			if (replay_ph == PH_IDLE) begin
				if (b == CH_CR) begin
					replay_ph = PH_LF1;
					replay_pos = 0;
					r.tx_byte = CH_CR;
					last_echoed = 1'b1;
				end else if (b == CH_BS) begin
					if (line_len != 0) begin
						line_len--;
						r.tx_byte = CH_BS;
						last_echoed = 1'b1;
					end
				end else if (line_len < LINE_STORE_DEPTH - 1) begin
					line_chars[line_len] = b;
					line_len++;
					r.tx_byte = b;
					last_echoed = 1'b1;
				end
			end
		end else begin
			case (replay_ph)
				PH_LF1: begin
					replay_ph = PH_CHARS;
					r.tx_byte = CH_LF;
					last_echoed = 1'b1;
				end
				PH_CHARS: begin
					if (replay_pos < line_len && line_chars[replay_pos] != 8'h00) begin
						r.tx_byte = line_chars[replay_pos];
						replay_pos++;
					end else begin
						replay_ph = PH_LF2;
						r.tx_byte = CH_CR;
					end
					last_echoed = 1'b1;
				end
				PH_CR2: begin
					replay_ph = PH_LF2;
					r.tx_byte = CH_CR;
					last_echoed = 1'b1;
				end
				PH_LF2: begin
					replay_ph = PH_IDLE;
					replay_pos = 0;
					line_len = 0;
					r.tx_byte = CH_LF;
					r.line_end = 1'b1;
					last_echoed = 1'b1;
				end
				default: replay_ph = PH_IDLE;
			endcase
		end
		if (last_echoed)
			tx_expected.push_back(r);
	endtask

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_beat(input bit req, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
			push <= 1'b1;
		end else if (!push) begin
			push <= 1'b1;
		end
		req_type <= req;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		edit_line(req, b);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (tx_expected.size() != 0);
	endtask

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_basic_edits();
		send_beat(REQ_TICK, 8'h00);
		send_beat(REQ_RX, CH_BS);
		send_beat(REQ_RX, 8'h41);
		send_beat(REQ_RX, 8'hFF);
		send_beat(REQ_RX, CH_BS);
		send_beat(REQ_RX, 8'h80);
		send_beat(REQ_RX, 8'h7F);
		send_beat(REQ_RX, 8'h01);
		send_beat(REQ_RX, 8'h00);
		send_beat(REQ_RX, 8'h55);
		send_beat(REQ_RX, CH_CR);
		send_beat(REQ_RX, 8'h78);
		send_beat(REQ_RX, CH_BS);
		send_beat(REQ_RX, CH_CR);
		while (replay_ph != PH_IDLE)
			send_beat(REQ_TICK, 8'hFF);
		send_beat(REQ_TICK, 8'hAA);
		send_beat(REQ_RX, CH_CR);
		while (replay_ph != PH_IDLE)
			send_beat(REQ_TICK, 8'h00);
		wait_drained();
	endtask

	task automatic test_full_line();
		logic [7:0] c;
		int i;
		for (i = 0; i < LINE_STORE_DEPTH - 1; i++) begin
			if (i == ZERO_AT) begin
				c = 8'h00;
			end else begin
				do
					c = any_byte();
				while (c == CH_CR || c == CH_BS || c == 8'h00);
			end
			send_beat(REQ_RX, c);
		end
		send_beat(REQ_RX, 8'h5A);
		send_beat(REQ_RX, 8'h00);
		send_beat(REQ_RX, CH_BS);
		send_beat(REQ_RX, 8'hA5);
		send_beat(REQ_RX, 8'h3C);
		send_beat(REQ_RX, CH_CR);
		while (replay_ph != PH_IDLE)
			send_beat(REQ_TICK, any_byte());
		wait_drained();
	endtask

	task automatic test_backpressure();
		steady = 1'b1;
		hold_req++;
		repeat (40)
			send_beat(REQ_RX, 8'($urandom_range(8'h20, 8'h7E)));
		send_beat(REQ_RX, CH_CR);
		while (replay_ph != PH_IDLE)
			send_beat(REQ_TICK, any_byte());
		steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_lines();
		int done;
		int len;
		int r;
		logic [7:0] c;
		done = 0;
		while (done < RANDOM_BEATS) begin
			steady = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) < 80) begin
				len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 12) : $urandom_range(13, 60);
				repeat (len) begin
					r = $urandom_range(0, 99);
					if (r < 10)
						c = CH_BS;
					else if (r < 15)
						c = 8'h00;
					else if (r < 17)
						c = CH_CR;
					else
						c = any_byte();
					send_beat(REQ_RX, c);
					done++;
				end
				send_beat(REQ_RX, CH_CR);
				done++;
				while (replay_ph != PH_IDLE) begin
					if ($urandom_range(0, 9) == 0)
						send_beat(REQ_RX, any_byte());
					else
						send_beat(REQ_TICK, any_byte());
					done++;
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					send_beat(1'($urandom_range(0, 1)), any_byte());
					done++;
				end
			end
		end
		steady = 1'b0;
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (steady) begin
			pop <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) < 4)
				stall_left = $urandom_range(10, 40);
			else if ($urandom_range(0, 99) < 25)
				stall_left = $urandom_range(1, 3);
			pop <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (tx_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat tx_byte=%h line_end=%b", $time, tx_byte, line_end);
			end else begin
				want = tx_expected.pop_front();
				if (tx_byte !== want.tx_byte) begin
					errors++;
					$display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, tx_byte);
				end
				if (line_end !== want.line_end) begin
					errors++;
					$display("%0t: line_end expected %b actual %b", $time, want.line_end,
						line_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d beats outstanding", $time,
				STALL_LIMIT, tx_expected.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_edits();
		test_full_line();
		test_backpressure();
		test_random_lines();
		repeat (20) @(posedge clk);
		if (errors == 0 && tx_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sle_front.sv
sv/sle_back.sv
sv/serial_line_editor_echo.sv
dv/serial_line_editor_echo_test.sv
